>>> hdl/derq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_pkg
// Shared types and constants for the double-ended ring queue: action and
// status codes, field widths and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package derq_pkg;

    // Fixed field widths
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int SUM_W  = CNT_W + 1;

    // Largest count/capacity the 5-bit fields can express
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_FRONT = 3'd4,
        ACT_READ_BACK  = 3'd5,
        ACT_CLEAR      = 3'd6,
        ACT_STATUS     = 3'd7
    } action_t;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the accepted item
        logic mod_start;  // launch the index reduction
        logic commit;     // memory access and head/count update
    } derq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mod_done;
    } derq_stat_t;

endpackage
`default_nettype wire

>>> hdl/derq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module derq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/derq_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_mod
// Iterative restoring remainder unit: one dividend bit per cycle, reduces a
// ring position sum modulo the effective capacity.
// ----------------------------------------------------------------------------
module derq_mod
    import derq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic      [CNT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  dvd_reg,  dvd_next;
    logic [CNT_W-1:0]  div_reg,  div_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [SUM_W-1:0]  trial;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[SUM_W-1]};
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = STEP_W'(SUM_W);
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = CNT_W'(trial);
            end
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operands and partial remainder
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> hdl/derq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_ctrl
// Sequencer for one queue action: latch, reduce index, access store, report.
// ----------------------------------------------------------------------------
module derq_ctrl
    import derq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire derq_stat_t stat,
    output derq_cmd_t       cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_START,
        S_MOD_WAIT,
        S_ACCESS,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MOD_START;
                        busy_reg  <= 1'b1;
                    end
                end
                S_MOD_START:
                begin
                    state_reg <= S_MOD_WAIT;
                end
                S_MOD_WAIT:
                begin
                    if (stat.mod_done)
                    begin
                        state_reg <= S_ACCESS;
                    end
                end
                S_ACCESS:
                begin
                    state_reg <= S_RESP;
                    done_reg  <= 1'b1;
                end
                S_RESP:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Datapath commands
    always_comb
    begin
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.mod_start = (state_reg == S_MOD_START);
        cmd.commit    = (state_reg == S_ACCESS);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

>>> hdl/derq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_dp
// Queue datapath: capacity register, head and count, entry store, index
// reduction unit and result registers.
// ----------------------------------------------------------------------------
module derq_dp
    import derq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire derq_cmd_t         cmd,
    output derq_stat_t             stat,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [DATA_W-1:0] item_data,
    output logic      [STAT_W-1:0] status,
    output logic      [DATA_W-1:0] read_data,
    output logic      [CNT_W-1:0]  entry_count,
    output logic                   is_empty,
    output logic                   is_full
);

    localparam int AW        = $clog2(DEPTH);
    localparam int SW        = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
    localparam int CAP_LIMIT = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  head_reg,   head_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  capeff_reg;
    logic [CNT_W-1:0]  capeff;
    action_t           action_reg;
    logic [SW-1:0]     data_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              rd_ok_reg,  rd_ok_next;

    logic [SUM_W-1:0]  mod_dvd;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;
    logic              q_full;
    logic              q_empty;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [SW-1:0]     ram_rdata;

    // Capacity clamped to 1..min(DEPTH, 31)
    always_comb
    begin
        if (cap_reg == '0)
        begin
            capeff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(CAP_LIMIT))
        begin
            capeff = CNT_W'(CAP_LIMIT);
        end
        else
        begin
            capeff = cap_reg;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Latched item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(action);
            data_reg   <= item_data[SW-1:0];
            capeff_reg <= capeff;
        end
    end

    // Ring position to reduce: head, back entry or slot after the back
    always_comb
    begin
        case (action_reg)
            ACT_PUSH_BACK:
            begin
                mod_dvd = {1'b0, head_reg} + {1'b0, count_reg};
            end
            ACT_POP_BACK, ACT_READ_BACK:
            begin
                mod_dvd = SUM_W'({1'b0, head_reg} + {1'b0, count_reg} - SUM_W'(1));
            end
            default:
            begin
                mod_dvd = {1'b0, head_reg};
            end
        endcase
    end

    derq_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (mod_dvd),
        .divisor   (capeff_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign stat.mod_done = mod_done;

    assign q_full  = (count_reg >= capeff_reg);
    assign q_empty = (count_reg == '0);

    // Action decode at commit
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        rd_ok_next  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = AW'(mod_rem);
        case (action_reg)
            ACT_PUSH_FRONT:
            begin
                if (q_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    head_next  = (mod_rem == '0) ? capeff_reg - CNT_W'(1)
                                                 : mod_rem - CNT_W'(1);
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(head_next);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_PUSH_BACK:
            begin
                if (q_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                if (q_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                    head_next  = (mod_rem + CNT_W'(1) == capeff_reg) ? '0
                                                                     : mod_rem + CNT_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_POP_BACK:
            begin
                if (q_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_READ_FRONT, ACT_READ_BACK:
            begin
                if (q_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    assign ram_raddr = AW'(mod_rem);

    derq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we && cmd.commit),
        .waddr (ram_waddr),
        .wdata (data_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    assign status      = status_reg;
    assign read_data   = rd_ok_reg ? DATA_W'(ram_rdata) : '0;
    assign entry_count = count_reg;
    assign is_empty    = q_empty;
    assign is_full     = q_full;

endmodule
`default_nettype wire

>>> hdl/double_ended_ring_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_ring_queue_core
// Fixed-capacity double-ended ring queue with push, pop and peek at both
// ends, clear and status query.
//
// Usage:
//   Command channel: drive action and item_data with start high; the item is
//   taken at a rising edge where start is high and busy is low. busy stays
//   high until the result has been shown.
//   Result channel: status, read_data, entry_count, is_empty and is_full are
//   valid for the single cycle in which done is high; the receiver cannot
//   stall, so it must capture them in that cycle.
//   Sequence: after the accepting edge the ring position is wrapped at the
//   programmed capacity by the bit-serial remainder unit, then the store is
//   accessed with a registered read and the result is registered; the next
//   item is taken only once busy has fallen after done.
//   Configuration: cfg_we writes cfg_wdata into the capacity register
//   (effective range 1..min(DEPTH,31)); write only while idle and follow
//   a capacity change with a clear.
//   Reset: head and count clear, capacity returns to 16, the entry store
//   keeps its data; user must not read it before it is written (unenforced).
// ----------------------------------------------------------------------------
module double_ended_ring_queue_core
    import derq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [DATA_W-1:0] item_data,
    output logic                   done,
    output logic      [STAT_W-1:0] status,
    output logic      [DATA_W-1:0] read_data,
    output logic      [CNT_W-1:0]  entry_count,
    output logic                   is_empty,
    output logic                   is_full,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata
);

    derq_cmd_t  cmd;
    derq_stat_t stat;

    derq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    derq_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .action      (action),
        .item_data   (item_data),
        .status      (status),
        .read_data   (read_data),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule
`default_nettype wire

>>> verif/derq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// derq_checker
// Watches the command, result and capacity ports of the ring queue core,
// keeps its own copy of the queue state, works out the expected result of
// every accepted item and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module derq_checker
    import derq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [ACT_W-1:0]  action,
    input  logic [DATA_W-1:0] item_data,
    input  logic              done,
    input  logic [STAT_W-1:0] status,
    input  logic [DATA_W-1:0] read_data,
    input  logic [CNT_W-1:0]  entry_count,
    input  logic              is_empty,
    input  logic              is_full,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    output int                mismatch_count,
    output int                outstanding,
    output int                results_checked,
    output int                refused_pushes,
    output int                refused_takes
);

    localparam int SLOTS      = 16;

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic [DATA_W-1:0] rdata;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              full;
    } deque_result_t;

    // Shadow of the queue
    logic [DATA_W-1:0] slot_words [SLOTS];
    int unsigned       front_pos;
    int unsigned       held;
    logic [CNT_W-1:0]  capacity_reg;

    deque_result_t     outcomes_due [$];

    initial
    begin
        mismatch_count  = 0;
        outstanding     = 0;
        results_checked = 0;
        refused_pushes  = 0;
        refused_takes   = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Capacity as the queue uses it: zero acts as one, clamp at the store depth
    function automatic int unsigned usable_capacity();
        if (capacity_reg == '0)
            return 1;
        if (capacity_reg > SLOTS)
            return SLOTS;
        return capacity_reg;
    endfunction

    // Applies one action to the shadow queue and returns what the core must show
    function automatic deque_result_t deque_outcome(input action_t act,
                                                    input logic [DATA_W-1:0] word);
        int unsigned   cap;
        int unsigned   pos;
        deque_result_t res;
        cap = usable_capacity();
        res = '0;
        res.stat = STAT_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (held >= cap)
                    res.stat = STAT_FULL;
                else if (act == ACT_PUSH_FRONT)
                begin
                    front_pos = (front_pos + cap - 1) % cap;
                    slot_words[front_pos] = word;
                    held++;
                end
                else
                begin
                    slot_words[(front_pos + held) % cap] = word;
                    held++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_READ_FRONT, ACT_READ_BACK:
            begin
                if (held == 0)
                    res.stat = STAT_EMPTY;
                else
                begin
                    if (act == ACT_POP_FRONT || act == ACT_READ_FRONT)
                        pos = front_pos % cap;
                    else
                        pos = (front_pos + held - 1) % cap;
                    res.rdata = slot_words[pos];
                    if (act == ACT_POP_FRONT)
                    begin
                        front_pos = (front_pos + 1) % cap;
                        held--;
                    end
                    else if (act == ACT_POP_BACK)
                        held--;
                end
            end
            ACT_CLEAR:
            begin
                front_pos = 0;
                held      = 0;
            end
            default:
                ;
        endcase
        res.count = held[CNT_W-1:0];
        res.empty = (held == 0);
        res.full  = (held >= cap);
        return res;
    endfunction

    // Compare results first, then capacity writes, then new items
    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            front_pos    = 0;
            held         = 0;
            capacity_reg = CAP_RESET;
            outcomes_due.delete();
            outstanding  = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (outcomes_due.size() == 0)
                    report_mismatch("result shown with no item waiting for one");
                else
                begin
                    want = outcomes_due.pop_front();
                    results_checked++;
                    compare_field("status", status, want.stat);
                    compare_field("read_data", read_data, want.rdata);
                    compare_field("entry_count", entry_count, want.count);
                    compare_field("is_empty", is_empty, want.empty);
                    compare_field("is_full", is_full, want.full);
                    if (want.stat == STAT_FULL)
                        refused_pushes++;
                    if (want.stat == STAT_EMPTY)
                        refused_takes++;
                end
            end
            if (cfg_we === 1'b1)
                capacity_reg = cfg_wdata;
            if (start === 1'b1 && busy === 1'b0)
                outcomes_due.push_back(deque_outcome(action_t'(action), item_data));
            outstanding = outcomes_due.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ring queue core with a directed opening (empty and full
// refusals, both ends, clear) and then random phases at
// several capacities, with and without a clear after each change. The
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import derq_pkg::*;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 20;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    action_t           action    = ACT_STATUS;
    logic [DATA_W-1:0] item_data = '0;
    logic              cfg_we    = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;

    logic              busy;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic              is_full;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int refused_pushes;
    int refused_takes;

    int idle_pct    = 38;
    int items_sent  = 0;
    int quiet_count = 0;

    double_ended_ring_queue_core #(
        .DEPTH      (16),
        .WORD_WIDTH (32)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .item_data   (item_data),
        .done        (done),
        .status      (status),
        .read_data   (read_data),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    derq_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .item_data       (item_data),
        .done            (done),
        .status          (status),
        .read_data       (read_data),
        .entry_count     (entry_count),
        .is_empty        (is_empty),
        .is_full         (is_full),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .refused_pushes  (refused_pushes),
        .refused_takes   (refused_takes)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: cycles with neither an item taken nor a result shown
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= STALL_LIMIT)
            begin
                $display("timeout: no item or result for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offers one item, holds it until taken, then maybe leaves a gap
    task automatic send_item(input action_t act, input logic [DATA_W-1:0] word);
        start     <= 1'b1;
        action    <= act;
        item_data <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // Hold off until every expected result is back and the core is idle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Push-heavy stretches reach full, pop-heavy stretches reach empty
    function automatic action_t pick_action(input bit fill_bias);
        int r;
        int push_t;
        int pop_t;
        int read_t;
        int clear_t;
        r       = $urandom_range(99);
        push_t  = fill_bias ? 55 : 20;
        pop_t   = fill_bias ? 75 : 60;
        read_t  = fill_bias ? 88 : 82;
        clear_t = fill_bias ? 90 : 86;
        if (r < push_t)
            return ($urandom_range(1) != 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        if (r < pop_t)
            return ($urandom_range(1) != 0) ? ACT_POP_BACK : ACT_POP_FRONT;
        if (r < read_t)
            return ($urandom_range(1) != 0) ? ACT_READ_BACK : ACT_READ_FRONT;
        if (r < clear_t)
            return ACT_CLEAR;
        return ACT_STATUS;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        action_t           opening [] = '{ACT_STATUS, ACT_POP_FRONT, ACT_POP_BACK,
                                          ACT_READ_FRONT, ACT_READ_BACK};
        action_t           closing [] = '{ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_READ_FRONT,
                                          ACT_READ_BACK, ACT_POP_FRONT, ACT_POP_BACK,
                                          ACT_POP_BACK, ACT_PUSH_FRONT, ACT_READ_FRONT,
                                          ACT_POP_FRONT, ACT_CLEAR, ACT_STATUS};
        logic [DATA_W-1:0] fill_words [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                              32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        logic [CNT_W-1:0]  phase_caps [NUM_PHASES];
        bit                fill_bias;
        int                burst_left;

        phase_caps = '{5'd0, 5'd31, 5'd5, 5'd1, 5'd16, 5'(2)};
        phase_caps[NUM_PHASES-1] = CNT_W'($urandom_range(2, 15));

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals on an empty queue
        foreach (opening[i])
            send_item(opening[i], pick_word());
        // Fill every store slot once so no later read can hit an unwritten one
        for (int i = 0; i < 16; i++)
            send_item(ACT_PUSH_BACK, (i < 6) ? fill_words[i] : $urandom);
        // Full refusals, both ends, a front push after a front pop, clear
        foreach (closing[i])
            send_item(closing[i], pick_word());
        drain_results();

        // Random phases; even ones clear after the capacity change, odd ones do not
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = (p < 2) ? 38 : ((p < 4) ? 45 : 0);
            write_capacity(phase_caps[p]);
            if (p % 2 == 0)
                send_item(ACT_CLEAR, pick_word());
            fill_bias  = 1'b1;
            burst_left = $urandom_range(8, 24);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (burst_left == 0)
                begin
                    fill_bias  = !fill_bias;
                    burst_left = $urandom_range(8, 24);
                end
                burst_left--;
                send_item(pick_action(fill_bias), pick_word());
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Run: %0d items sent, %0d results checked, %0d pushes refused as full, %0d pops/reads refused as empty",
                 items_sent, results_checked, refused_pushes, refused_takes);
        $display("Capacities written: %0d %0d %0d %0d %0d %0d, half of them without a clear",
                 phase_caps[0], phase_caps[1], phase_caps[2], phase_caps[3],
                 phase_caps[4], phase_caps[5]);
        if (mismatch_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
